FILE: sv/crc_pkg.sv
// Package for the Catmull-Rom curve point core.
// Holds widths, reset values and shared types; no dependencies.
package crc_pkg;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned PosW      = 16;
  localparam int unsigned CountW    = 7;
  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned WeightW   = 33;
  localparam int unsigned ProdW     = WeightW + CoordW;
  localparam int unsigned AccW      = ProdW + 2;
  localparam logic [CountW-1:0] CountReset = 7'd4;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;
endpackage

FILE: sv/crc_in_if.sv
// Input channel of the curve point core.
// Depends on crc_pkg.
interface crc_in_if import crc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [5:0]               point_slot;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic [PosW-1:0]          curve_position;
  modport source (output valid, operation, point_slot, coord_x, coord_y, coord_z,
                  curve_position, input ready);
  modport sink (input valid, operation, point_slot, coord_x, coord_y, coord_z,
                curve_position, output ready);
endinterface

FILE: sv/crc_out_if.sv
// Output channel of the curve point core.
// Depends on crc_pkg.
interface crc_out_if import crc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

FILE: sv/crc_cfg_if.sv
// Configuration write channel of the curve point core.
// Depends on crc_pkg.
interface crc_cfg_if import crc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: sv/catmull_rom_curve_point_core.sv
// Top level of the closed uniform Catmull-Rom curve point core.
// Depends on crc_pkg, the channel interfaces, crc_front and crc_back; crc_ram is used through crc_front.
//
//   channel  dir  carries
//   in_ch    in   operation, point_slot, coord_x/y/z, curve_position
//   out_ch   out  point_x/y/z
//   cfg_ch   in   active_points
//
// One item per cycle while the input is not stalled: a write goes into the table on
// acceptance, an evaluate passes the table read, four arithmetic stages and the result queue.
// The four multipliers per axis in the product stage set the clock.
// Reset clears the count register to four; the point table is not cleared.
// An output stall fills a small result queue before the input stalls.
module catmull_rom_curve_point_core import crc_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  crc_in_if.sink    in_ch,
  crc_out_if.source out_ch,
  crc_cfg_if.sink   cfg_ch
);
  logic [CountW-1:0] active_q;
  logic              ev_valid, ev_ready;
  logic [PosW-1:0]   ev_frac;
  point_t            ev_p [4];
  point_t            res;
  point_t            in_pt;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CountReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      active_q <= cfg_ch.data;
    end
  end

  assign in_pt.x = in_ch.coord_x;
  assign in_pt.y = in_ch.coord_y;
  assign in_pt.z = in_ch.coord_z;

  crc_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_o       (in_ch.ready),
    .operation_i      (in_ch.operation),
    .point_slot_i     (in_ch.point_slot),
    .point_i          (in_pt),
    .curve_position_i (in_ch.curve_position),
    .active_points_i  (active_q),
    .ev_valid_o       (ev_valid),
    .ev_ready_i       (ev_ready),
    .ev_frac_o        (ev_frac),
    .ev_p_o           (ev_p)
  );

  crc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_ready_o  (ev_ready),
    .ev_frac_i   (ev_frac),
    .ev_p_i      (ev_p),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_o       (res)
  );

  assign out_ch.point_x = res.x;
  assign out_ch.point_y = res.y;
  assign out_ch.point_z = res.z;
endmodule

FILE: sv/crc_front.sv
// Front end: writes each control point into all four replicated tables and, for an evaluate,
// computes segment, fraction and the four wrapped indices. Depends on crc_pkg.
module crc_front import crc_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault,
  parameter int unsigned IdxW = $clog2(MaxPoints)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            operation_i,
  input  logic [5:0]      point_slot_i,
  input  point_t          point_i,
  input  logic [PosW-1:0] curve_position_i,
  input  logic [CountW-1:0] active_points_i,
  output logic            ev_valid_o,
  input  logic            ev_ready_i,
  output logic [PosW-1:0] ev_frac_o,
  output point_t          ev_p_o [4]
);
  localparam int unsigned NW = $clog2(MaxPoints + 1);
  localparam int unsigned CntW = (NW > CountW) ? NW : CountW;

  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] n_raw;
  logic [PosW+CntW-1:0] u;
  logic [CntW-1:0] seg;
  logic [CntW:0]   id_raw [4];
  logic [IdxW-1:0] idx [4];
  logic            s0_valid_q;
  logic [PosW-1:0] s0_frac_q;
  logic            accept;
  logic            wr_en;
  logic            stall;

  assign n_raw = CntW'(active_points_i);
  always_comb begin
    n_eff = n_raw;
    if (n_raw < CntW'(4)) n_eff = CntW'(4);
    if (n_raw > CntW'(MaxPoints)) n_eff = CntW'(MaxPoints);
  end

  assign u   = PosW'(curve_position_i) * n_eff;
  assign seg = u[PosW +: CntW];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      id_raw[k] = {1'b0, seg} + (CntW+1)'(k) + {1'b0, n_eff} - (CntW+1)'(1);
      if (id_raw[k] >= {1'b0, n_eff}) id_raw[k] = id_raw[k] - {1'b0, n_eff};
      if (id_raw[k] >= {1'b0, n_eff}) id_raw[k] = id_raw[k] - {1'b0, n_eff};
      idx[k] = id_raw[k][IdxW-1:0];
    end
  end

  assign stall      = s0_valid_q && !ev_ready_i;
  assign in_ready_o = !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (op_e'(operation_i) == OP_WRITE) &&
                      (32'(point_slot_i) < MaxPoints);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    crc_ram #(.Width($bits(point_t)), .Depth(MaxPoints)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en),
      .waddr_i (IdxW'(point_slot_i)),
      .wdata_i (point_i),
      .re_i    (!stall),
      .raddr_i (idx[k]),
      .rdata_o (ev_p_o[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (!stall) begin
      s0_valid_q <= accept && (op_e'(operation_i) == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) s0_frac_q <= u[PosW-1:0];
  end

  assign ev_valid_o = s0_valid_q;
  assign ev_frac_o  = s0_frac_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(s0_frac_q)) else $error("fraction changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> op_e'(operation_i) == OP_WRITE) else $error("bad write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_e'(operation_i) == OP_EVAL) |=> s0_valid_q)
    else $error("evaluate lost");
endmodule

FILE: sv/crc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module crc_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 64,
  parameter int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/crc_back.sv
// Back end: basis weights, blend of the four points, rounding and saturation,
// with a six-entry result queue at the output. Depends on crc_pkg.
module crc_back import crc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ev_valid_i,
  output logic            ev_ready_o,
  input  logic [PosW-1:0] ev_frac_i,
  input  point_t          ev_p_i [4],
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output point_t          out_o
);
  localparam int unsigned Depth = 6;

  // Stage 1: T^2 and carry.
  logic [1:0]  v_q;
  logic        v3_q, v4_q;
  logic [PosW-1:0] t1_q;
  logic [2*PosW-1:0] t2_q;
  point_t p1_q [4];
  // Stage 2: T^3 and weights.
  logic [3*PosW-1:0] t3_full;
  logic signed [WeightW-1:0] w_d [4];
  logic signed [WeightW-1:0] w_q [4];
  point_t p2_q [4];
  // Stage 3: products.
  logic signed [ProdW-1:0] pr_q [3][4];
  // Stage 4: sum, round, saturate.
  point_t res_d, res_q;

  logic [3:0] inflight;
  logic       push, pop;
  logic [2:0] fq_cnt_q;
  point_t     fq_q [Depth];
  logic [2:0] fq_wp_q, fq_rp_q;

  assign inflight = 4'(v_q[0]) + 4'(v_q[1]) + 4'(v3_q) + 4'(v4_q) + 4'(fq_cnt_q);
  assign ev_ready_o = inflight < 4'(Depth);

  always_comb begin
    logic signed [63:0] a3, a2, a1, one, tmp;
    logic signed [63:0] wx [4];
    a3  = 64'($unsigned(t3_full));
    a2  = 64'(t2_q) <<< 16;
    a1  = 64'(t1_q) <<< 32;
    one = 64'sd1 <<< 48;
    wx[0] = -a3 + 2*a2 - a1;
    wx[1] = 3*a3 - 5*a2 + 2*one;
    wx[2] = -3*a3 + 4*a2 + a1;
    wx[3] = a3 - a2;
    for (int k = 0; k < 4; k++) begin
      tmp = (wx[k] + (64'sd1 <<< 18)) >>> 19;
      w_d[k] = WeightW'(tmp);
    end
  end
  assign t3_full = t2_q * t1_q;

  always_comb begin
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] r;
    logic signed [CoordW-1:0] o [3];
    for (int j = 0; j < 3; j++) begin
      acc = AccW'(pr_q[j][0]) + AccW'(pr_q[j][1]) + AccW'(pr_q[j][2]) + AccW'(pr_q[j][3]);
      r = (acc + (AccW'(1) <<< 29)) >>> 30;
      if (r > AccW'(32'sh7fffffff)) o[j] = 32'sh7fffffff;
      else if (r < -AccW'(64'sh80000000)) o[j] = 32'sh80000000;
      else o[j] = r[CoordW-1:0];
    end
    res_d = '{x: o[0], y: o[1], z: o[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v_q[0] <= ev_valid_i && ev_ready_o;
      v_q[1] <= v_q[0];
      v3_q   <= v_q[1];
      v4_q   <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q <= ev_frac_i;
    t2_q <= ev_frac_i * ev_frac_i;
    p1_q <= ev_p_i;
    w_q  <= w_d;
    p2_q <= p1_q;
    for (int k = 0; k < 4; k++) begin
      pr_q[0][k] <= w_q[k] * p2_q[k].x;
      pr_q[1][k] <= w_q[k] * p2_q[k].y;
      pr_q[2][k] <= w_q[k] * p2_q[k].z;
    end
    res_q <= res_d;
  end

  // Output queue; depth covers the items in flight behind ready.
  assign push = v4_q;
  assign pop  = out_valid_o && out_ready_i;
  assign out_valid_o = fq_cnt_q != 3'(0);
  assign out_o = fq_q[fq_rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_cnt_q <= '0;
      fq_wp_q <= '0;
      fq_rp_q <= '0;
    end else begin
      if (push) fq_wp_q <= (fq_wp_q == 3'(Depth-1)) ? 3'(0) : fq_wp_q + 3'(1);
      if (pop)  fq_rp_q <= (fq_rp_q == 3'(Depth-1)) ? 3'(0) : fq_rp_q + 3'(1);
      fq_cnt_q <= fq_cnt_q + 3'(push) - 3'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) fq_q[fq_wp_q] <= res_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_cnt_q <= 3'(Depth)) else $error("output queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |=> v_q[1]) else $error("pipeline lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fq_cnt_q == 3'(Depth))) else $error("push into full queue");
endmodule
